/* design/ktd_pkg.sv */
package ktd_pkg;

	localparam int NUM_CYL_DEF = 4;
	localparam int DW = 16;
	localparam int PC_W = 4;

	localparam logic [DW-1:0] SAMPLE_SCALE_RST = 16'd32768;
	localparam logic [DW-1:0] MAD_COEFF_RST = 16'd4096;
	localparam logic [DW-1:0] MAD_MAX_RST = 16'hFFFF;
	localparam logic [DW-1:0] MAD_STATE_RST = 16'hFFFF;

	typedef enum logic [2:0] {
		REG_SAMPLE_FLOOR = 3'd0,
		REG_SAMPLE_SCALE = 3'd1,
		REG_AVERAGE_FLOOR = 3'd2,
		REG_AVERAGE_INIT = 3'd3,
		REG_MAD_COEFF = 3'd4,
		REG_MAD_MIN = 3'd5,
		REG_MAD_MAX = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_FLOOR,
		OP_SCALE,
		OP_SAT,
		OP_AVG_MUL,
		OP_AVG_UPD,
		OP_MAD_MUL,
		OP_MAD_UPD,
		OP_BAND_MUL,
		OP_THR,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_OOR,
		COND_SKIP_MAD
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [PC_W-1:0] target;
		logic last;
	} ctrl_t;

	typedef struct packed {
		logic oor;
		logic skip_mad;
	} flags_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	localparam logic [PC_W-1:0] PC_BAND = 4'd7;
	localparam logic [PC_W-1:0] PC_DONE = 4'd9;

	function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{op: OP_DONE, cond: COND_NONE, target: '0, last: 1'b1};
		case (pc)
			4'd0: w = '{op: OP_FLOOR, cond: COND_NONE, target: '0, last: 1'b0};
			4'd1: w = '{op: OP_SCALE, cond: COND_NONE, target: '0, last: 1'b0};
			4'd2: w = '{op: OP_SAT, cond: COND_OOR, target: PC_DONE, last: 1'b0};
			4'd3: w = '{op: OP_AVG_MUL, cond: COND_NONE, target: '0, last: 1'b0};
			4'd4: w = '{op: OP_AVG_UPD, cond: COND_NONE, target: '0, last: 1'b0};
			4'd5: w = '{op: OP_MAD_MUL, cond: COND_SKIP_MAD, target: PC_BAND, last: 1'b0};
			4'd6: w = '{op: OP_MAD_UPD, cond: COND_NONE, target: '0, last: 1'b0};
			4'd7: w = '{op: OP_BAND_MUL, cond: COND_NONE, target: '0, last: 1'b0};
			4'd8: w = '{op: OP_THR, cond: COND_NONE, target: '0, last: 1'b0};
			default: w = '{op: OP_DONE, cond: COND_NONE, target: '0, last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

/* design/knock_threshold_detector_core.sv */
// Channel   Direction  Handshake                  Payload
// sample    in         sample_valid/sample_stall  cyl_id raw_sample avg_coeff mad_update_allowed
//                                                 detect_enabled noise_multiplier
// result    out        result_valid/result_stall  out_cyl knock_seen scaled_sample
//                                                 knock_threshold new_average new_mad
// config    in         cfg_valid/cfg_ready        cfg_index cfg_data
//
// One transaction runs a 10-step microprogram over one shared 16x16 multiplier:
// an unknown cylinder jumps from the saturation step to the final step, a sample with
// no deviation update skips that update step, and the next sample can be taken in the cycle after the final step.
// sample_stall is high while the program runs; a result waits in the output
// register, and the final step holds until that register is free.
// Reset loads averages with 0 and deviations with 65535; no clearing pass.
module knock_threshold_detector_core
	import ktd_pkg::*;
#(
	parameter int NUM_CYL = NUM_CYL_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_stall,
	input  logic [1:0]    cyl_id,
	input  logic [DW-1:0] raw_sample,
	input  logic [DW-1:0] avg_coeff,
	input  logic          mad_update_allowed,
	input  logic          detect_enabled,
	input  logic [DW-1:0] noise_multiplier,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [1:0]    out_cyl,
	output logic          knock_seen,
	output logic [DW-1:0] scaled_sample,
	output logic [DW-1:0] knock_threshold,
	output logic [DW-1:0] new_average,
	output logic [DW-1:0] new_mad,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [DW-1:0] cfg_data
);

	localparam int CW = (NUM_CYL > 1) ? $clog2(NUM_CYL) : 1;

	logic [DW-1:0] sample_floor_q, sample_scale_q, average_floor_q;
	logic [DW-1:0] mad_coeff_q, mad_min_q, mad_max_q;
	logic [DW-1:0] avg_mem_q [NUM_CYL];
	logic [DW-1:0] mad_mem_q [NUM_CYL];

	logic [1:0] cyl_q;
	logic [DW-1:0] raw_q, acoef_q, mult_q;
	logic mad_ok_q, det_q;

	logic [DW-1:0] samp_q, avg_q, mad_q, thr_q, lag_old_q;
	logic [2*DW-1:0] prod_q;
	logic dir_q;

	logic accept, busy, out_free, run, cfg_wr, load_out;
	ctrl_t ctrl;
	flags_t flags;
	logic [CW-1:0] idx;
	logic oor;

	logic [DW-1:0] mul_a, mul_b, old_v, tgt_v, diff_v, lag_res, avg_new, mad_hi, mad_new;
	logic [DW-1:0] band, dev_v;
	logic [2*DW-1:0] mul_p;
	logic [DW:0] up_sum, thr_sum;
	logic [2*DW:0] dn_round;
	logic [DW:0] dn_step;
	logic dir_v;

	logic result_valid_q;

	assign accept = sample_valid && !sample_stall;
	assign sample_stall = busy;
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign out_free = !result_valid_q || !result_stall;
	assign run = busy;
	assign load_out = run && (ctrl.op == OP_DONE) && out_free;

	assign idx = CW'(cyl_q);
	assign oor = (32'(cyl_q) >= 32'(NUM_CYL));
	assign dev_v = avg_q - samp_q;

	assign flags.oor = oor;
	assign flags.skip_mad = !(mad_ok_q && (avg_q >= samp_q));

	ktd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_free (out_free),
		.flags    (flags),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	always_comb begin
		old_v = mad_q;
		tgt_v = dev_v;
		mul_b = mad_coeff_q;
		case (ctrl.op)
			OP_AVG_MUL: begin
				old_v = avg_mem_q[idx];
				tgt_v = samp_q;
				mul_b = acoef_q;
			end
			OP_SCALE: mul_b = sample_scale_q;
			OP_BAND_MUL: mul_b = mult_q;
			default: mul_b = mad_coeff_q;
		endcase
	end

	assign dir_v = (tgt_v >= old_v);
	assign diff_v = dir_v ? (tgt_v - old_v) : (old_v - tgt_v);

	always_comb begin
		case (ctrl.op)
			OP_SCALE: mul_a = samp_q;
			OP_BAND_MUL: mul_a = mad_q;
			default: mul_a = diff_v;
		endcase
	end

	assign mul_p = (2*DW)'(mul_a) * (2*DW)'(mul_b);

	assign up_sum = {1'b0, lag_old_q} + {1'b0, prod_q[2*DW-1:DW]};
	assign dn_round = {1'b0, prod_q} + (2*DW+1)'(16'hFFFF);
	assign dn_step = dn_round[2*DW:DW];

	always_comb begin
		if (dir_q) begin
			lag_res = up_sum[DW-1:0];
		end else if (dn_step > {1'b0, lag_old_q}) begin
			lag_res = '0;
		end else begin
			lag_res = lag_old_q - dn_step[DW-1:0];
		end
	end

	assign avg_new = (lag_res < average_floor_q) ? average_floor_q : lag_res;
	assign mad_hi = (lag_res > mad_max_q) ? mad_max_q : lag_res;
	assign mad_new = (mad_hi < mad_min_q) ? mad_min_q : mad_hi;

	assign band = (prod_q[2*DW-1:DW+10] != '0) ? '1 : prod_q[DW+9:10];
	assign thr_sum = {1'b0, avg_q} + {1'b0, band};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_floor_q <= '0;
			sample_scale_q <= SAMPLE_SCALE_RST;
			average_floor_q <= '0;
			mad_coeff_q <= MAD_COEFF_RST;
			mad_min_q <= '0;
			mad_max_q <= MAD_MAX_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_SAMPLE_FLOOR: sample_floor_q <= cfg_data;
				REG_SAMPLE_SCALE: sample_scale_q <= cfg_data;
				REG_AVERAGE_FLOOR: average_floor_q <= cfg_data;
				REG_MAD_COEFF: mad_coeff_q <= cfg_data;
				REG_MAD_MIN: mad_min_q <= cfg_data;
				REG_MAD_MAX: mad_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CYL; i++) begin
				avg_mem_q[i] <= '0;
				mad_mem_q[i] <= MAD_STATE_RST;
			end
		end else begin
			if (cfg_wr && (cfg_index == REG_AVERAGE_INIT)) begin
				for (int i = 0; i < NUM_CYL; i++) begin
					avg_mem_q[i] <= cfg_data;
				end
			end else if (run && (ctrl.op == OP_AVG_UPD)) begin
				avg_mem_q[idx] <= avg_new;
			end
			if (run && (ctrl.op == OP_MAD_UPD)) begin
				mad_mem_q[idx] <= mad_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cyl_q <= cyl_id;
			raw_q <= raw_sample;
			acoef_q <= avg_coeff;
			mad_ok_q <= mad_update_allowed;
			det_q <= detect_enabled;
			mult_q <= noise_multiplier;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			case (ctrl.op)
				OP_FLOOR: samp_q <= (raw_q < sample_floor_q) ? sample_floor_q : raw_q;
				OP_SCALE: prod_q <= mul_p;
				OP_SAT: samp_q <= prod_q[2*DW-1] ? '1 : prod_q[2*DW-2:DW-1];
				OP_AVG_MUL, OP_MAD_MUL: begin
					prod_q <= mul_p;
					lag_old_q <= old_v;
					dir_q <= dir_v;
				end
				OP_AVG_UPD: begin
					avg_q <= avg_new;
					mad_q <= mad_mem_q[idx];
				end
				OP_MAD_UPD: mad_q <= mad_new;
				OP_BAND_MUL: prod_q <= mul_p;
				OP_THR: thr_q <= thr_sum[DW] ? '1 : thr_sum[DW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cyl <= cyl_q;
			scaled_sample <= samp_q;
			knock_seen <= !oor && det_q && (samp_q > thr_q);
			knock_threshold <= oor ? '0 : thr_q;
			new_average <= oor ? '0 : avg_q;
			new_mad <= oor ? '0 : mad_q;
		end
	end

	assign result_valid = result_valid_q;

endmodule

/* design/ktd_seq.sv */
module ktd_seq
	import ktd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   out_free,
	input  flags_t flags,
	output ctrl_t  ctrl,
	output logic   busy
);

	seq_state_t state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	ctrl_t word;
	logic take_jump;

	assign word = ucode_rom(pc_q);

	always_comb begin
		case (word.cond)
			COND_OOR: take_jump = flags.oor;
			COND_SKIP_MAD: take_jump = flags.skip_mad;
			default: take_jump = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_d = SEQ_RUN;
					pc_d = '0;
				end
			end
			SEQ_RUN: begin
				if (word.last) begin
					if (out_free) begin
						state_d = SEQ_IDLE;
					end
				end else if (take_jump) begin
					pc_d = word.target;
				end else begin
					pc_d = pc_q + PC_W'(1);
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		ctrl = word;
		busy = (state_q == SEQ_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q <= '0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
		end
	end

endmodule

/* design/ktd_chk.sv */
module ktd_chk
	import ktd_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	input logic          sample_valid,
	input logic          sample_stall,
	input logic          result_valid,
	input logic          result_stall,
	input logic          knock_seen,
	input logic [1:0]    out_cyl,
	input logic [DW-1:0] scaled_sample,
	input logic [DW-1:0] knock_threshold,
	input logic [DW-1:0] new_average,
	input logic [DW-1:0] new_mad
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_cyl)
			&& $stable(scaled_sample) && $stable(knock_threshold)
			&& $stable(new_average) && $stable(new_mad) && $stable(knock_seen))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample taken while a transaction is in flight");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result without a transaction in flight");

	a_knock: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && knock_seen |-> scaled_sample > knock_threshold)
		else $error("knock flagged at or below threshold");

	a_thr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> knock_threshold >= new_average)
		else $error("threshold below average");

endmodule

bind knock_threshold_detector_core ktd_chk u_ktd_chk (.*);
